// ----- design/group_dynamic_precision_detector_unit_defines.svh -----
// Assertion macros for the group dynamic precision detector.
`ifndef GROUP_DYNAMIC_PRECISION_DETECTOR_UNIT_DEFINES_SVH
`define GROUP_DYNAMIC_PRECISION_DETECTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define GDPD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define GDPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDPD_ASSERT(label, clk, rst_n, prop, msg)
`define GDPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- design/gdpd_pkg.sv -----
// Types, register indexes and helper functions for the precision detector.
package gdpd_pkg;

  localparam int unsigned FieldBits = 16;
  localparam int unsigned PosBits   = 5;
  localparam int unsigned CostBits  = 9;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 5;

  localparam logic [PosBits-1:0] NoBit = 5'd31;

  localparam logic [CfgIdxBits-1:0] CfgPeWidth      = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgSignedMode   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgTrimLow      = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgSkipZeroWgt  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgNetworkWidth = 3'd4;

  typedef struct packed {
    logic [4:0] act_bits;
    logic       signed_mode;
    logic       trim_low;
    logic       skip_zero_weight;
    logic [4:0] serial_mult;
  } gdpd_cfg_t;

  // 0 acts as 1, anything above 16 acts as 16
  function automatic logic [4:0] clamp_1_16(input logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (v > 5'd16) begin
      r = 5'd16;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [PosBits-1:0] lowest_set(input logic [FieldBits-1:0] f);
    logic [PosBits-1:0] r;
    r = NoBit;
    for (int i = FieldBits - 1; i >= 0; i--) begin
      if (f[i]) begin
        r = PosBits'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [PosBits-1:0] highest_set(input logic [FieldBits-1:0] f);
    logic [PosBits-1:0] r;
    r = '0;
    for (int i = 0; i < FieldBits; i++) begin
      if (f[i]) begin
        r = PosBits'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [PosBits-1:0] width_of(input logic [PosBits-1:0] low,
                                                  input logic [PosBits-1:0] high,
                                                  input logic trim,
                                                  input logic sgn);
    logic [PosBits-1:0] r;
    if (trim) begin
      if (low > high) begin
        r = PosBits'(5'd1 + {4'd0, sgn});
      end else begin
        r = high - low + 5'd1;
      end
    end else begin
      r = high + 5'd1;
    end
    return r;
  endfunction

endpackage

// ----- design/group_dynamic_precision_detector_unit.sv -----
// Group dynamic precision detector: per-element cost and per-group width.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | request   | in_valid_i/in_stall_o | act_word, block_index, weight_zero, group_last
//  out     | result    | out_valid_o/out_stall_i | element_cost, group_width, group_done
//  cfg     | write     | cfg_valid_i/cfg_ready_o | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall_i is low; a result passes through
// the input register, then the result register, before it reaches the outputs.
// Group low/high bit state is read and updated as a request moves into the
// result register, so consecutive requests of one group chain without gaps.
// Reset clears control state and sets the configuration to its defaults; no clearing pass.
// out_stall_i holds the result register, and the input register fills behind it.
`include "group_dynamic_precision_detector_unit_defines.svh"

module group_dynamic_precision_detector_unit #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [WORD_BITS-1:0]         act_word_i,
  input  logic [3:0]                   block_index_i,
  input  logic                         weight_zero_i,
  input  logic                         group_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gdpd_pkg::CostBits-1:0] element_cost_o,
  output logic [gdpd_pkg::PosBits-1:0]  group_width_o,
  output logic                         group_done_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gdpd_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [gdpd_pkg::CfgDataBits-1:0] cfg_data_i
);
  import gdpd_pkg::*;

  localparam int unsigned ExtBits = WORD_BITS + FieldBits;

  gdpd_cfg_t cfg_q;

  logic                 s1_valid_q;
  logic [WORD_BITS-1:0] s1_word_q;
  logic [3:0]           s1_blk_q;
  logic                 s1_wz_q;
  logic                 s1_last_q;

  logic                 out_valid_q;
  logic [CostBits-1:0]  cost_q, cost_d;
  logic [PosBits-1:0]   gw_q, gw_d;
  logic                 done_q;

  logic [PosBits-1:0]   grp_low_q, grp_low_d;
  logic [PosBits-1:0]   grp_high_q, grp_high_d;
  logic [PosBits-1:0]   grp_low_upd, grp_high_upd;

  logic                 out_adv;
  logic                 s1_adv;

  logic [4:0]           pw, nw;
  logic                 sgn;
  logic [7:0]           shift;
  logic [ExtBits-1:0]   word_ext;
  logic [ExtBits-1:0]   word_sh;
  logic [FieldBits-1:0] mask;
  logic [FieldBits-1:0] field_raw;
  logic [FieldBits-1:0] field;
  logic [PosBits-1:0]   el_low, el_high;
  logic [PosBits-1:0]   el_width;
  logic [9:0]           el_prod;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.act_bits         <= 5'd16;
      cfg_q.signed_mode      <= 1'b0;
      cfg_q.trim_low         <= 1'b0;
      cfg_q.skip_zero_weight <= 1'b0;
      cfg_q.serial_mult      <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPeWidth:      cfg_q.act_bits         <= cfg_data_i;
        CfgSignedMode:   cfg_q.signed_mode      <= cfg_data_i[0];
        CfgTrimLow:      cfg_q.trim_low         <= cfg_data_i[0];
        CfgSkipZeroWgt:  cfg_q.skip_zero_weight <= cfg_data_i[0];
        CfgNetworkWidth: cfg_q.serial_mult      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_word_q <= act_word_i;
      s1_blk_q  <= block_index_i;
      s1_wz_q   <= weight_zero_i;
      s1_last_q <= group_last_i;
    end
  end

  // field extraction and bit detection
  always_comb begin
    pw        = clamp_1_16(cfg_q.act_bits);
    nw        = clamp_1_16(cfg_q.serial_mult);
    sgn       = cfg_q.signed_mode;
    shift     = 8'(pw * s1_blk_q);
    word_ext  = {{FieldBits{1'b0}}, s1_word_q};
    word_sh   = word_ext >> shift;
    mask      = FieldBits'((17'd1 << pw) - 17'd1);
    field_raw = word_sh[FieldBits-1:0] & mask;
    if (sgn && field_raw[4'(pw - 5'd1)]) begin
      field = field_raw ^ mask;
    end else begin
      field = field_raw;
    end
    el_low   = lowest_set(field);
    el_high  = highest_set(field) + {4'd0, sgn};
    el_width = width_of(el_low, el_high, cfg_q.trim_low, sgn);
    el_prod  = {5'd0, el_width} * {5'd0, nw};
    if (cfg_q.skip_zero_weight && s1_wz_q) begin
      cost_d = '0;
    end else begin
      cost_d = el_prod[CostBits-1:0];
    end

    grp_low_upd  = (el_low != NoBit && el_low < grp_low_q) ? el_low : grp_low_q;
    grp_high_upd = (el_high > grp_high_q) ? el_high : grp_high_q;

    if (s1_last_q) begin
      gw_d       = width_of(grp_low_upd, grp_high_upd, cfg_q.trim_low, sgn);
      grp_low_d  = NoBit;
      grp_high_d = '0;
    end else begin
      gw_d       = '0;
      grp_low_d  = grp_low_upd;
      grp_high_d = grp_high_upd;
    end
  end

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_low_q  <= NoBit;
      grp_high_q <= '0;
    end else if (out_adv && s1_valid_q) begin
      grp_low_q  <= grp_low_d;
      grp_high_q <= grp_high_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      cost_q <= cost_d;
      gw_q   <= gw_d;
      done_q <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign element_cost_o = cost_q;
  assign group_width_o  = gw_q;
  assign group_done_o   = done_q;

  `GDPD_ASSERT(a_group_clears, clk_i, rst_ni, (out_adv && s1_valid_q && s1_last_q) |=> (grp_low_q == NoBit && grp_high_q == '0), "group state not cleared after group end")
  `GDPD_ASSERT(a_width_only_done, clk_i, rst_ni, (out_valid_q && !done_q) |-> (gw_q == '0), "group width set outside group end")
  `GDPD_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i), "input stalled without a full pipeline")
  `GDPD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!out_valid_o && !s1_valid_q), "pipeline not empty after reset")

endmodule

// ----- test/group_dynamic_precision_detector_unit_test.sv -----
// Self-checking testbench for the group dynamic precision detector: directed and random groups.
`timescale 1ns / 1ps

module group_dynamic_precision_detector_unit_test;

  localparam int unsigned WordBits = 16;

  typedef struct packed {
    logic [gdpd_pkg::CostBits-1:0] cost;
    logic [gdpd_pkg::PosBits-1:0]  width;
    logic                          done;
  } precision_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic [WordBits-1:0]                act_word_i = '0;
  logic [3:0]                         block_index_i = '0;
  logic                               weight_zero_i = 1'b0;
  logic                               group_last_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic [gdpd_pkg::CostBits-1:0]      element_cost_o;
  logic [gdpd_pkg::PosBits-1:0]       group_width_o;
  logic                               group_done_o;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [gdpd_pkg::CfgIdxBits-1:0]    cfg_index_i = '0;
  logic [gdpd_pkg::CfgDataBits-1:0]   cfg_data_i = '0;

  // shadow registers and group state
  logic [4:0]  cur_act_bits = 5'd16;
  logic        cur_signed = 1'b0;
  logic        cur_trim_low = 1'b0;
  logic        cur_skip_zero = 1'b0;
  logic [4:0]  cur_net_width = 5'd16;
  int unsigned grp_low_bit = 31;
  int unsigned grp_high_bit = 0;

  precision_t  precision_q[$];
  int unsigned fail_count = 0;

  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          sink_hold_req = 1'b0;
  int unsigned sink_hold_left = 0;
  int unsigned sink_stall_left = 0;

  group_dynamic_precision_detector_unit #(
    .WORD_BITS(WordBits)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .act_word_i    (act_word_i),
    .block_index_i (block_index_i),
    .weight_zero_i (weight_zero_i),
    .group_last_i  (group_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .element_cost_o(element_cost_o),
    .group_width_o (group_width_o),
    .group_done_o  (group_done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned clamp_width(input logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > 5'd16) return 16;
    return v;
  endfunction

  function automatic int unsigned span_of(input int unsigned lo, hi, sgn);
    if (cur_trim_low) return (lo > hi) ? 1 + sgn : hi - lo + 1;
    return hi + 1;
  endfunction

  // cost and group width for one accepted request; advances the group state
  function automatic precision_t detect_precision(input logic [WordBits-1:0] word,
                                                  input logic [3:0] blk,
                                                  input logic wz, input logic last);
    int unsigned pw, nw, sgn, shift, lo, hi, ew;
    logic [15:0] field;
    precision_t r;
    pw = clamp_width(cur_act_bits);
    nw = clamp_width(cur_net_width);
    sgn = cur_signed;
    shift = pw * blk;
    field = '0;
    for (int unsigned i = 0; i < pw; i++) begin
      if (shift + i < WordBits) begin
        field[i] = word[shift + i];
      end
    end
    if (sgn != 0 && field[pw - 1]) begin
      field = field ^ 16'((32'd1 << pw) - 1);
    end
    lo = 31;
    hi = 0;
    for (int unsigned i = 0; i < pw; i++) begin
      if (field[i]) begin
        if (lo == 31) lo = i;
        hi = i;
      end
    end
    hi += sgn;
    ew = span_of(lo, hi, sgn);
    r.cost = (cur_skip_zero && wz) ? '0 : gdpd_pkg::CostBits'(ew * nw);
    if (lo != 31 && lo < grp_low_bit) grp_low_bit = lo;
    if (hi > grp_high_bit) grp_high_bit = hi;
    r.width = '0;
    r.done = 1'b0;
    if (last) begin
      r.width = gdpd_pkg::PosBits'(span_of(grp_low_bit, grp_high_bit, sgn));
      r.done = 1'b1;
      grp_low_bit = 31;
      grp_high_bit = 0;
    end
    return r;
  endfunction

  function automatic logic [WordBits-1:0] pick_word();
    logic [WordBits-1:0] w;
    w = WordBits'($urandom);
    case ($urandom_range(0, 3))
      0: w = w >> $urandom_range(0, 15);
      1: w = w << $urandom_range(0, 15);
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) w = '0;
    return w;
  endfunction

  // mostly blocks that overlap the word, sometimes any index
  function automatic logic [3:0] pick_block();
    int unsigned pw, nblk;
    pw = clamp_width(cur_act_bits);
    nblk = (WordBits + pw - 1) / pw;
    if ($urandom_range(0, 3) == 0 || nblk > 16) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, nblk - 1));
  endfunction

  task automatic send_act(input logic [WordBits-1:0] word, input logic [3:0] blk,
                          input logic wz, input logic last);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    act_word_i    <= word;
    block_index_i <= blk;
    weight_zero_i <= wz;
    group_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    precision_q.push_back(detect_precision(word, blk, wz, last));
  endtask

  task automatic send_random(input logic last);
    send_act(pick_word(), pick_block(), 1'($urandom), last);
  endtask

  // stop sending and wait until every request has its result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (precision_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gdpd_pkg::CfgIdxBits-1:0] idx,
                           input logic [gdpd_pkg::CfgDataBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gdpd_pkg::CfgPeWidth:      cur_act_bits = val;
      gdpd_pkg::CfgSignedMode:   cur_signed = val[0];
      gdpd_pkg::CfgTrimLow:      cur_trim_low = val[0];
      gdpd_pkg::CfgSkipZeroWgt:  cur_skip_zero = val[0];
      gdpd_pkg::CfgNetworkWidth: cur_net_width = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [4:0] pe, input logic sgn, input logic trim,
                             input logic skip, input logic [4:0] nw);
    write_reg(gdpd_pkg::CfgPeWidth, pe);
    write_reg(gdpd_pkg::CfgSignedMode, {4'($urandom), sgn});
    write_reg(gdpd_pkg::CfgTrimLow, {4'($urandom), trim});
    write_reg(gdpd_pkg::CfgSkipZeroWgt, {4'($urandom), skip});
    write_reg(gdpd_pkg::CfgNetworkWidth, nw);
    // unused index must be ignored
    write_reg(gdpd_pkg::CfgIdxBits'(gdpd_pkg::CfgNetworkWidth + $urandom_range(1, 3)),
              gdpd_pkg::CfgDataBits'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_act(16'h0000, 4'd0, 1'b0, 1'b1);
    send_act(16'hFFFF, 4'd0, 1'b1, 1'b0);
    send_act(16'h0001, 4'd0, 1'b0, 1'b1);
    send_act(16'h8000, 4'd0, 1'b0, 1'b1);
    send_act(16'h1234, 4'd15, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_signed_trim();
    load_config(5'd4, 1'b1, 1'b1, 1'b1, 5'd3);
    send_act(16'h00F0, 4'd1, 1'b0, 1'b0);
    send_act(16'h0080, 4'd1, 1'b1, 1'b0);
    send_act(16'h0007, 4'd0, 1'b0, 1'b0);
    send_act(16'hFFFF, 4'd3, 1'b1, 1'b1);
    send_act(16'h0000, 4'd2, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_register_extremes();
    load_config(5'd0, 1'b0, 1'b1, 1'b0, 5'd0);
    send_act(16'h8000, 4'd15, 1'b0, 1'b0);
    send_act(16'h0008, 4'd3, 1'b1, 1'b1);
    send_act(16'h0000, 4'd0, 1'b0, 1'b1);
    send_act(16'h0004, 4'd2, 1'b1, 1'b0);
    settle();
    // group left open across a register change
    load_config(5'd31, 1'b1, 1'b0, 1'b1, 5'd31);
    send_act(16'hC000, 4'd0, 1'b1, 1'b0);
    send_act(16'h8000, 4'd0, 1'b0, 1'b1);
    send_act(16'h0000, 4'd0, 1'b0, 1'b1);
    send_act(16'hFFFF, 4'd1, 1'b0, 1'b1);
    settle();
    load_config(5'd5, 1'b0, 1'b0, 1'b0, 5'd16);
    send_act(16'hC000, 4'd3, 1'b0, 1'b0);
    send_act(16'hFFFF, 4'd2, 1'b0, 1'b1);
    settle();
    load_config(5'd16, 1'b0, 1'b1, 1'b1, 5'd1);
    send_act(16'hFFFF, 4'd0, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_random_groups();
    int unsigned sent, glen;
    repeat (9) begin
      load_config(($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)),
                  1'($urandom), 1'($urandom), 1'($urandom),
                  ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)));
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 50) begin
        glen = $urandom_range(1, 8);
        for (int unsigned k = 0; k < glen; k++) begin
          send_random(k == glen - 1 || $urandom_range(0, 15) == 0);
          sent++;
        end
      end
      settle();
    end
  endtask

  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    load_config(5'd8, 1'b1, 1'b0, 1'b0, 5'd7);
    sink_hold_req = 1'b1;
    repeat (30) send_random($urandom_range(0, 3) == 0);
    settle();
    repeat (10) send_random($urandom_range(0, 3) == 0);
    settle();
  endtask

  task automatic test_steady_stream();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    load_config(5'd3, 1'b0, 1'b1, 1'b0, 5'd16);
    repeat (40) send_random($urandom_range(0, 2) == 0);
    send_random(1'b1);
    settle();
  endtask

  // receiver stall: long hold on request, random bursts otherwise
  always @(posedge clk_i) begin : sink_stall
    if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (sink_hold_req) begin
      sink_hold_req = 1'b0;
      sink_hold_left <= 80;
      out_stall_i <= 1'b1;
    end else if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
      sink_stall_left <= $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    precision_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (precision_q.size() == 0) begin
        $display("%0t: result with no request: cost %0d width %0d done %0d",
                 $time, element_cost_o, group_width_o, group_done_o);
        fail_count++;
      end else begin
        want = precision_q.pop_front();
        if (element_cost_o !== want.cost) begin
          $display("%0t: element_cost expected %0d, actual %0d", $time, want.cost,
                   element_cost_o);
          fail_count++;
        end
        if (group_width_o !== want.width) begin
          $display("%0t: group_width expected %0d, actual %0d", $time, want.width,
                   group_width_o);
          fail_count++;
        end
        if (group_done_o !== want.done) begin
          $display("%0t: group_done expected %0d, actual %0d", $time, want.done,
                   group_done_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_signed_trim();
    test_register_extremes();
    test_random_groups();
    test_backpressure();
    test_steady_stream();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && precision_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
